// ===== src/srsu_pkg.sv =====
// ----------------------------------------------------------------------------
// srsu_pkg
// shared types and codes of the shift/rotate unit pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srsu_pkg;

   // shift kinds
   localparam logic [1:0] MODE_ARITH  = 2'd0;
   localparam logic [1:0] MODE_ROTATE = 2'd1;
   localparam logic [1:0] MODE_ZERO   = 2'd2;
   localparam logic [1:0] MODE_LINK   = 2'd3;

   // operand selects
   localparam logic [1:0] TGT_T    = 2'd0;
   localparam logic [1:0] TGT_D    = 2'd1;
   localparam logic [1:0] TGT_A    = 2'd2;
   localparam logic [1:0] TGT_PAIR = 2'd3;

   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 56;

   // link bit on top, operand window below
   localparam int unsigned WORD_W = 65;

   typedef struct packed {
      logic                vld;
      logic                right;
      logic [1:0]          target;
      logic [4:0]          steps;
      logic [WORD_W-1:0]   word;
      logic [15:0]         reg_t;
      logic [15:0]         reg_d;
      logic [15:0]         reg_a;
   } stage_type;

endpackage

`default_nettype wire

// ===== src/register_shift_rotate_unit_core.sv =====
// ----------------------------------------------------------------------------
// register_shift_rotate_unit_core
// shift/rotate unit with link bit for the T, D, A registers and the A:D pair
// ----------------------------------------------------------------------------
// one shift word in and one result word out per cycle while rsp is not
// stalled; the stages are operand decode, barrel stages for 16/8 and 4/2/1,
// and the output register. the whole pipeline advances whenever the output
// register is empty or being taken, so a stall on rsp holds every stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module register_shift_rotate_unit_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // mode[1:0] target[3:2] count[9:4] reg_t_in[25:10] reg_d_in[41:26]
   // reg_a_in[57:42] link_in[58]
   input  wire logic [srsu_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // reg_t_out[15:0] reg_d_out[31:16] reg_a_out[47:32] link_out[48]
   output logic [srsu_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   logic                en;
   srsu_pkg::stage_type dec_q;
   srsu_pkg::stage_type mid_q;
   srsu_pkg::stage_type shf_q;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   srsu_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_tvalid),
      .in_data (req_tdata),
      .out_q   (dec_q)
   );

   srsu_shifter u_shifter (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in_q  (dec_q),
      .mid_q (mid_q),
      .out_q (shf_q)
   );

   srsu_pack u_pack (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_q     (shf_q),
      .out_vld  (rsp_tvalid),
      .out_data (rsp_tdata)
   );

   // no word leaves right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a held result freezes the shifter stages
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(shf_q) && $stable(mid_q)))
      else $error("pipeline moved during stall");

   // zero steps pass every register through unchanged
   a_zero_pass: assert property (@(posedge clock) disable iff (reset)
      (en && shf_q.vld && shf_q.steps == 5'd0) |=>
      (rsp_tdata[15:0] == $past(shf_q.reg_t) && rsp_tdata[31:16] == $past(shf_q.reg_d)
       && rsp_tdata[47:32] == $past(shf_q.reg_a)))
      else $error("zero step shift changed a register");

endmodule

`default_nettype wire

// ===== src/srsu_decode.sv =====
// ----------------------------------------------------------------------------
// srsu_decode
// input stage: picks the operand, builds the fill window and the step count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srsu_decode (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              in_vld,
   input  wire logic [srsu_pkg::REQ_DATA_W-1:0]   in_data,
   output srsu_pkg::stage_type                    out_q
);

   srsu_pkg::stage_type stage_ff, stage_in;

   logic [1:0]  mode;
   logic [1:0]  target;
   logic [5:0]  count;
   logic [5:0]  count_neg;
   logic [15:0] reg_t, reg_d, reg_a;
   logic        link;
   logic        right;
   logic        wide;
   logic        rotate;
   logic        sign;
   logic        fill;
   logic [15:0] v16;
   logic [31:0] v32;
   logic [31:0] f32;
   logic [47:0] f48;
   logic [63:0] win_left;
   logic [63:0] win_right;
   logic [63:0] win_right_rev;

   always_comb begin
      mode      = in_data[1:0];
      target    = in_data[3:2];
      count     = in_data[9:4];
      reg_t     = in_data[25:10];
      reg_d     = in_data[41:26];
      reg_a     = in_data[57:42];
      link      = in_data[58];
      right     = count[5];
      count_neg = 6'd0 - count;
      wide      = (target == srsu_pkg::TGT_PAIR);
      rotate    = (mode == srsu_pkg::MODE_ROTATE);

      unique case (target)
         srsu_pkg::TGT_T: v16 = reg_t;
         srsu_pkg::TGT_D: v16 = reg_d;
         srsu_pkg::TGT_A: v16 = reg_a;
         default:         v16 = reg_a;
      endcase
      v32  = {reg_a, reg_d};
      sign = wide ? reg_a[15] : v16[15];

      unique case (mode)
         srsu_pkg::MODE_ARITH:  fill = right & sign;
         srsu_pkg::MODE_ROTATE: fill = 1'b0;
         srsu_pkg::MODE_ZERO:   fill = 1'b0;
         srsu_pkg::MODE_LINK:   fill = link;
         default:               fill = 1'b0;
      endcase

      f48 = rotate ? {v16, v16, v16} : {48{fill}};
      f32 = rotate ? v32 : {32{fill}};

      // left: operand top-aligned; right: operand bottom-aligned, then mirrored
      win_left  = wide ? {v32, f32} : {v16, f48};
      win_right = wide ? {f32, v32} : {f48, v16};
      for (int i = 0; i < 64; i++) begin
         win_right_rev[i] = win_right[63-i];
      end

      stage_in.vld    = in_vld;
      stage_in.right  = right;
      stage_in.target = target;
      stage_in.steps  = right ? count_neg[4:0] : count[4:0];
      stage_in.word   = right ? {link, win_right_rev} : {link, win_left};
      stage_in.reg_t  = reg_t;
      stage_in.reg_d  = reg_d;
      stage_in.reg_a  = reg_a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.vld <= 1'b0;
      end else if (en) begin
         stage_ff.vld <= stage_in.vld;
      end
      if (en) begin
         stage_ff.right  <= stage_in.right;
         stage_ff.target <= stage_in.target;
         stage_ff.steps  <= stage_in.steps;
         stage_ff.word   <= stage_in.word;
         stage_ff.reg_t  <= stage_in.reg_t;
         stage_ff.reg_d  <= stage_in.reg_d;
         stage_ff.reg_a  <= stage_in.reg_a;
      end
   end

   assign out_q = stage_ff;

endmodule

`default_nettype wire

// ===== src/srsu_shifter.sv =====
// ----------------------------------------------------------------------------
// srsu_shifter
// two-stage barrel shifter: 16 and 8 in the first stage, 4, 2 and 1 next
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srsu_shifter (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           en,
   input  srsu_pkg::stage_type in_q,
   output srsu_pkg::stage_type mid_q,
   output srsu_pkg::stage_type out_q
);

   srsu_pkg::stage_type hi_ff, hi_in;
   srsu_pkg::stage_type lo_ff, lo_in;

   logic [srsu_pkg::WORD_W-1:0] w16, w8, w4, w2, w1;

   always_comb begin
      w16   = in_q.steps[4] ? (in_q.word << 16) : in_q.word;
      w8    = in_q.steps[3] ? (w16 << 8) : w16;
      hi_in = in_q;
      hi_in.word = w8;
   end

   always_comb begin
      w4    = hi_ff.steps[2] ? (hi_ff.word << 4) : hi_ff.word;
      w2    = hi_ff.steps[1] ? (w4 << 2) : w4;
      w1    = hi_ff.steps[0] ? (w2 << 1) : w2;
      lo_in = hi_ff;
      lo_in.word = w1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff.vld <= 1'b0;
         lo_ff.vld <= 1'b0;
      end else if (en) begin
         hi_ff.vld <= hi_in.vld;
         lo_ff.vld <= lo_in.vld;
      end
      if (en) begin
         hi_ff.right  <= hi_in.right;
         hi_ff.target <= hi_in.target;
         hi_ff.steps  <= hi_in.steps;
         hi_ff.word   <= hi_in.word;
         hi_ff.reg_t  <= hi_in.reg_t;
         hi_ff.reg_d  <= hi_in.reg_d;
         hi_ff.reg_a  <= hi_in.reg_a;
         lo_ff.right  <= lo_in.right;
         lo_ff.target <= lo_in.target;
         lo_ff.steps  <= lo_in.steps;
         lo_ff.word   <= lo_in.word;
         lo_ff.reg_t  <= lo_in.reg_t;
         lo_ff.reg_d  <= lo_in.reg_d;
         lo_ff.reg_a  <= lo_in.reg_a;
      end
   end

   assign mid_q = hi_ff;
   assign out_q = lo_ff;

endmodule

`default_nettype wire

// ===== src/srsu_pack.sv =====
// ----------------------------------------------------------------------------
// srsu_pack
// output stage: unmirrors right shifts and merges the result into the word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srsu_pack (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  srsu_pkg::stage_type                    in_q,
   output logic                                   out_vld,
   output logic [srsu_pkg::RSP_DATA_W-1:0]        out_data
);

   logic                              vld_ff;
   logic [srsu_pkg::RSP_DATA_W-1:0]   data_ff, data_in;

   logic [31:0] top32, rev32, val32;
   logic [15:0] top16, rev16, val16;
   logic [15:0] new_t, new_d, new_a;

   always_comb begin
      top32 = in_q.word[63:32];
      top16 = in_q.word[63:48];
      for (int i = 0; i < 32; i++) begin
         rev32[i] = top32[31-i];
      end
      for (int i = 0; i < 16; i++) begin
         rev16[i] = top16[15-i];
      end
      val32 = in_q.right ? rev32 : top32;
      val16 = in_q.right ? rev16 : top16;

      new_t = in_q.reg_t;
      new_d = in_q.reg_d;
      new_a = in_q.reg_a;
      unique case (in_q.target)
         srsu_pkg::TGT_T: new_t = val16;
         srsu_pkg::TGT_D: new_d = val16;
         srsu_pkg::TGT_A: new_a = val16;
         srsu_pkg::TGT_PAIR: begin
            new_a = val32[31:16];
            new_d = val32[15:0];
         end
         default: new_t = in_q.reg_t;
      endcase

      data_in = {7'd0, in_q.word[64], new_a, new_d, new_t};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_q.vld;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;

endmodule

`default_nettype wire
